// ===== design/dmx_pkg.sv =====
// Package: shared types and constants for the DMX/RDM frame receiver.
`default_nettype none
package dmx_pkg;
    localparam int PIXEL_SLOTS = 6;
    localparam logic [15:0] NONE_YET = 16'hffff;

    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0, REQ_BREAK = 2'd1, REQ_TIMEOUT = 2'd2, REQ_NOP = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_START, ST_DMX, ST_SUB, ST_LEN, ST_BODY, ST_CK_HI, ST_CK_LO, ST_POST, ST_DISCARD
    } frame_state_t;

    typedef enum logic [3:0] {
        EV_NONE = 4'd0, EV_DMX = 4'd1, EV_RDM = 4'd2, EV_ALT = 4'd3, EV_SUB_BAD = 4'd4,
        EV_LEN_BAD = 4'd5, EV_PDL_BAD = 4'd6, EV_CK_BAD = 4'd7, EV_LEN_MISMATCH = 4'd8,
        EV_SHORT = 4'd9
    } event_t;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        req_t       req;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       pixel_write;
        logic       pixel_index;
        logic [1:0] pixel_color;
        logic [7:0] pixel_value;
        logic       pixel_begin;
        logic       pixel_commit;
        logic       rdm_request_ok;
        logic [3:0] event_code;
        logic [15:0] dmx_slot_count;
        logic [15:0] dmx_slot_min;
        logic [15:0] dmx_slot_max;
        logic [7:0] dmx_sum;
    } result_t;
endpackage
`default_nettype wire

// ===== design/dmx_rdm_frame_receiver.sv =====
// Top level of the DMX512/RDM frame receiver.
// One item per clock: each accepted item (byte, break, timeout) yields exactly
// one result item, sustained at one item per cycle unless m_tready stalls. A
// two-entry queue buffers input items ahead of the frame state machine, whose
// result register frees as soon as the result is taken. An item passes through
// the queue register and then the result register. The user must write
// own_uid on the cfg channel only while idle; the block itself does not
// enforce this. tdata in: [1:0] req_type, [9:2] data_byte. Result tdata packs
// the result fields from pixel_write upward (75 bits, padded to 80).
`default_nettype none
module dmx_rdm_frame_receiver import dmx_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [47:0] cfg_data,       // own_uid
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,        // req_type[1:0], data_byte[9:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata         // pixel_write..dmx_sum, low bit up
);
    logic [47:0] uid_reg;
    cmd_t        in_cmd, q_cmd;
    logic        q_valid, q_ready;
    result_t     res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) uid_reg <= '0;
        else if (cfg_valid) uid_reg <= cfg_data;
    end

    assign in_cmd.req  = req_t'(s_tdata[1:0]);
    assign in_cmd.data = s_tdata[9:2];

    dmx_front u_front (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd, .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd));

    dmx_back u_back (.aclk, .aresetn, .own_uid(uid_reg), .in_valid(q_valid),
        .in_ready(q_ready), .in_cmd(q_cmd), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_res(res));

    assign m_tdata = {5'd0, res.dmx_sum, res.dmx_slot_max, res.dmx_slot_min,
        res.dmx_slot_count, res.event_code, res.rdm_request_ok, res.pixel_commit,
        res.pixel_begin, res.pixel_value, res.pixel_color, res.pixel_index,
        res.pixel_write};

    a_ev_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:15] <= 4'd9) else $error("bad event code");
    a_ok_no_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[14]) |-> m_tdata[18:15] == 4'd0) else $error("ok with event");
    a_pw_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> m_tdata[11:1] == 11'd0) else $error("stray pixel");
endmodule
`default_nettype wire

// ===== design/dmx_front.sv =====
// Front part: two-entry item queue ahead of the frame engine.
`default_nettype none
module dmx_front import dmx_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  cmd_t      in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);
    cmd_t       q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = q_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= in_cmd;
        if (!aresetn) begin
            rd_reg <= 1'b0; wr_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== design/dmx_back.sv =====
// Back part: frame state machine, checks, statistics and result register.
`default_nettype none
module dmx_back import dmx_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [47:0] own_uid,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  cmd_t             in_cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output result_t          out_res
);
    frame_state_t st_reg, st_next;
    logic [15:0] off_reg, off_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] rsum_reg, rsum_next;
    logic [7:0]  ckhi_reg, ckhi_next;
    logic [47:0] duid_reg, duid_next;
    logic [15:0] cnt_reg, cnt_next, min_reg, min_next, max_reg, max_next;
    logic [7:0]  ssum_reg, ssum_next;
    logic        ov_reg;
    result_t     res_reg, res_next;
    logic        take, for_us;
    logic [15:0] s;
    logic [4:0]  s_div3;
    logic [7:0]  b;

    assign in_ready  = !ov_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    assign b = in_cmd.data;
    assign s = off_reg - 16'd1;
    // Slot divided by three via reciprocal multiply, exact for slots below 64.
    assign s_div3 = 5'((12'(s[5:0]) * 12'd43) >> 7);
    assign for_us = (duid_reg == own_uid) || ((duid_reg[31:0] == 32'hffffffff) &&
                    ((duid_reg[47:32] == 16'hffff) || (duid_reg[47:32] == own_uid[47:32])));

    always_comb begin
        st_next = st_reg; off_next = off_reg; len_next = len_reg; rsum_next = rsum_reg;
        ckhi_next = ckhi_reg; duid_next = duid_reg; cnt_next = cnt_reg;
        min_next = min_reg; max_next = max_reg; ssum_next = ssum_reg;
        res_next = '0;
        unique case (in_cmd.req)
            REQ_BREAK: begin
                if (st_reg == ST_DMX && (min_reg == NONE_YET || cnt_reg < min_reg))
                    min_next = cnt_reg;
                if (st_reg == ST_SUB || st_reg == ST_LEN ||
                    (st_reg == ST_BODY && off_reg < 16'd9))
                    res_next.event_code = EV_SHORT;
                off_next = '0;
                st_next = ST_START;
            end
            REQ_TIMEOUT: res_next.pixel_commit = 1'b1;
            REQ_NOP: ;
            REQ_BYTE: begin
                unique case (st_reg)
                    ST_START: begin
                        if (b == 8'h00) begin
                            ssum_next = '0; cnt_next = '0; st_next = ST_DMX;
                            res_next.pixel_begin = 1'b1; res_next.event_code = EV_DMX;
                        end else if (b == 8'hcc) begin
                            rsum_next = {8'd0, b}; duid_next = '0; st_next = ST_SUB;
                            res_next.event_code = EV_RDM;
                        end else begin
                            st_next = ST_DISCARD; res_next.event_code = EV_ALT;
                        end
                    end
                    ST_SUB: begin
                        if (b != 8'h01) begin
                            st_next = ST_DISCARD; res_next.event_code = EV_SUB_BAD;
                        end else begin
                            rsum_next = rsum_reg + {8'd0, b}; st_next = ST_LEN;
                        end
                    end
                    ST_LEN: begin
                        if (b < 8'd24) begin
                            st_next = ST_DISCARD; res_next.event_code = EV_LEN_BAD;
                        end else begin
                            len_next = b; rsum_next = rsum_reg + {8'd0, b}; st_next = ST_BODY;
                        end
                    end
                    ST_BODY: begin
                        if (off_reg == 16'd23 && b != len_reg - 8'd24) begin
                            st_next = ST_DISCARD; res_next.event_code = EV_PDL_BAD;
                        end else begin
                            rsum_next = rsum_reg + {8'd0, b};
                            if (off_reg >= 16'd3 && off_reg <= 16'd8)
                                duid_next = {duid_reg[39:0], b};
                            if (off_reg + 16'd1 == {8'd0, len_reg}) st_next = ST_CK_HI;
                        end
                    end
                    ST_CK_HI: begin
                        ckhi_next = b; st_next = ST_CK_LO;
                    end
                    ST_CK_LO: begin
                        if ({ckhi_reg, b} == rsum_reg) res_next.rdm_request_ok = 1'b1;
                        else if (for_us) res_next.event_code = EV_CK_BAD;
                        st_next = ST_POST;
                    end
                    ST_POST: begin
                        if (for_us) res_next.event_code = EV_LEN_MISMATCH;
                        st_next = ST_DISCARD;
                    end
                    ST_DMX: begin
                        if (s < 16'(PIXEL_SLOTS)) begin
                            res_next.pixel_write = 1'b1;
                            res_next.pixel_index = s_div3[0];
                            res_next.pixel_color = 2'(s[5:0] - 6'(s_div3) * 6'd3);
                            res_next.pixel_value = b;
                        end else if (s == 16'(PIXEL_SLOTS)) begin
                            res_next.pixel_commit = 1'b1;
                        end
                        ssum_next = ssum_reg + b;
                        if (cnt_reg < 16'hfffe) cnt_next = cnt_reg + 16'd1;
                        if (max_reg == NONE_YET || cnt_next > max_reg) max_next = cnt_next;
                    end
                    default: ;
                endcase
                if (off_reg != 16'hffff) off_next = off_reg + 16'd1;
            end
            default: ;
        endcase
        res_next.dmx_slot_count = cnt_next;
        res_next.dmx_slot_min   = min_next;
        res_next.dmx_slot_max   = max_next;
        res_next.dmx_sum        = ssum_next;
    end

    always_ff @(posedge aclk) begin
        if (take) res_reg <= res_next;
        if (!aresetn) begin
            st_reg <= ST_START; off_reg <= '0; len_reg <= '0; rsum_reg <= '0;
            ckhi_reg <= '0; duid_reg <= '0; cnt_reg <= '0; min_reg <= NONE_YET;
            max_reg <= NONE_YET; ssum_reg <= '0; ov_reg <= 1'b0;
        end else begin
            if (take) begin
                st_reg <= st_next; off_reg <= off_next; len_reg <= len_next;
                rsum_reg <= rsum_next; ckhi_reg <= ckhi_next; duid_reg <= duid_next;
                cnt_reg <= cnt_next; min_reg <= min_next; max_reg <= max_next;
                ssum_reg <= ssum_next;
            end
            if (take) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire
